@@ src/rsa_pkg.sv @@
// ----------------------------------------------------------------------------
// rsa_pkg
// Shared sizes, register codes and constant tables for the raster slope block.
// ----------------------------------------------------------------------------
`default_nettype none

package rsa_pkg;

    localparam int MAX_COLUMNS    = 1024;
    localparam int MAX_ROWS       = 1024;
    localparam int ELEVATION_BITS = 24;

    // History ring holds two rows plus three cells of the window.
    localparam int HIST_DEPTH = 2 * MAX_COLUMNS + 3;
    localparam int HIST_AW    = $clog2(HIST_DEPTH);
    localparam int CELL_W     = ELEVATION_BITS + 1;

    localparam int COL_W = $clog2(MAX_COLUMNS + 1);
    localparam int ROW_W = $clog2(MAX_ROWS + 1);
    localparam int CNT_W = $clog2(MAX_COLUMNS * MAX_ROWS);

    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 3;
    localparam int ANGLE_W   = 23;
    localparam int INDEX_W   = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_NEIGHBOR_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UNIT_MODE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_X_RECIPROCAL  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_RECIPROCAL  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT     = 3'd5;

    // Stencil sum, magnitude and gradient widths.
    localparam int SUM_W  = ELEVATION_BITS + 4;
    localparam int MAG_W  = ELEVATION_BITS + 3;
    localparam int PROD_W = MAG_W + 16;
    localparam int T_W    = PROD_W + 1;
    localparam int GRAD_W = 47;
    localparam logic [63:0] GRAD_CAP = (64'd1 << GRAD_W) - 64'd1;

    // CORDIC datapath.
    localparam int CW        = 36;
    localparam int Z_W       = 27;
    localparam int DEG_W     = 30;
    localparam int DP_W      = Z_W - 1 + DEG_W;
    localparam logic [DEG_W-1:0] DEG_SCALE = 30'd961263669;
    localparam logic [ANGLE_W-1:0] NINETY_Q16  = 23'd5898240;
    localparam logic [ANGLE_W-1:0] HALF_PI_Q16 = 23'd102944;

    function automatic logic signed [Z_W-1:0] atan_q24(input logic [4:0] i);
        logic signed [Z_W-1:0] r;
        begin
            unique case (i)
                5'd0:    r = 27'sd13176795;
                5'd1:    r = 27'sd7778716;
                5'd2:    r = 27'sd4110060;
                5'd3:    r = 27'sd2086331;
                5'd4:    r = 27'sd1047214;
                5'd5:    r = 27'sd524117;
                5'd6:    r = 27'sd262123;
                5'd7:    r = 27'sd131069;
                5'd8:    r = 27'sd65536;
                5'd9:    r = 27'sd32768;
                5'd10:   r = 27'sd16384;
                5'd11:   r = 27'sd8192;
                5'd12:   r = 27'sd4096;
                5'd13:   r = 27'sd2048;
                5'd14:   r = 27'sd1024;
                5'd15:   r = 27'sd512;
                5'd16:   r = 27'sd256;
                5'd17:   r = 27'sd128;
                5'd18:   r = 27'sd64;
                5'd19:   r = 27'sd32;
                5'd20:   r = 27'sd16;
                5'd21:   r = 27'sd8;
                5'd22:   r = 27'sd4;
                5'd23:   r = 27'sd2;
                default: r = '0;
            endcase
            return r;
        end
    endfunction

endpackage

`default_nettype wire

@@ src/raster_slope_angle.sv @@
// ----------------------------------------------------------------------------
// raster_slope_angle
// Slope angle of a row-major elevation raster from a 3x3 history window.
// A cell that yields no result stays in idle; a cell that yields a result skips the
// square root and CORDIC when a neighbor is missing or the gradient is zero.
// A full result runs the eight history reads through the single read port, the 32-step
// square root and the 24-step CORDIC loop, all run one item at a time.
// Reset is asynchronous: control and configuration registers take their defaults, the cell
// counter clears, and the history memory and datapath registers are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module raster_slope_angle (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_write,
    input  wire logic [rsa_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [rsa_pkg::CFG_W-1:0]            cfg_data,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic signed [rsa_pkg::ELEVATION_BITS-1:0] elevation,
    input  wire logic                                 elevation_valid,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic [rsa_pkg::ANGLE_W-1:0]               slope_angle,
    output logic                                      slope_valid,
    output logic [rsa_pkg::INDEX_W-1:0]               cell_index
);

    import rsa_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_READ   = 11'b00000000010,
        S_SUM    = 11'b00000000100,
        S_MUL    = 11'b00000001000,
        S_NORM   = 11'b00000010000,
        S_SQ     = 11'b00000100000,
        S_SQRT   = 11'b00001000000,
        S_PRE    = 11'b00010000000,
        S_CORDIC = 11'b00100000000,
        S_CONV   = 11'b01000000000,
        S_DONE   = 11'b10000000000
    } state_t;

    localparam int E = ELEVATION_BITS;

    state_t state_reg;

    logic        neighbor_mode_reg, unit_mode_reg;
    logic [31:0] x_recip_reg, y_recip_reg;
    logic [10:0] column_count_reg, row_count_reg;

    logic [CNT_W-1:0]   cell_counter_reg;
    logic [HIST_AW-1:0] wptr_reg;

    // Per-item registers.
    logic [CNT_W-1:0]   j_reg;
    logic [HIST_AW-1:0] wcur_reg;
    logic [COL_W-1:0]   nc_reg;
    logic [CELL_W-1:0]  cur_reg;
    logic [CELL_W-1:0]  win_reg [0:7];
    logic [3:0]         rd_idx_reg;
    logic [MAG_W-1:0]   mx_reg, my_reg;
    logic [2:0]         mstep_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [T_W-1:0]     tx_reg, ty_reg;
    logic [GRAD_W-1:0]  gx_reg, gy_reg;
    logic [4:0]         s_reg;
    logic               sqstep_reg;
    logic [62:0]        sq_reg;
    logic [62:0]        n_reg;
    logic [63:0]        res_reg;
    logic [4:0]         it_reg;
    logic signed [CW-1:0]  x_reg, y_reg;
    logic signed [Z_W-1:0] z_reg;
    logic               cstep_reg;
    logic [DP_W-1:0]    dp_reg;
    logic [ANGLE_W-1:0] angle_reg;
    logic               ok_reg;

    logic               out_valid_reg;
    logic [ANGLE_W-1:0] slope_angle_reg;
    logic               slope_valid_reg;
    logic [INDEX_W-1:0] cell_index_reg;

    // ---------------------------------------------------------------- sizes
    logic [COL_W-1:0] nc;
    logic [ROW_W-1:0] nr;
    logic [CNT_W:0]   total;

    always_comb
    begin
        if (column_count_reg < 11'd3)
            nc = COL_W'(3);
        else if (32'(column_count_reg) > MAX_COLUMNS)
            nc = COL_W'(MAX_COLUMNS);
        else
            nc = COL_W'(column_count_reg);
        if (row_count_reg < 11'd3)
            nr = ROW_W'(3);
        else if (32'(row_count_reg) > MAX_ROWS)
            nr = ROW_W'(MAX_ROWS);
        else
            nr = ROW_W'(row_count_reg);
    end

    assign total = (CNT_W + 1)'(nc) * (CNT_W + 1)'(nr);

    logic               accept;
    logic               restart;
    logic [CNT_W-1:0]   j_eff;
    logic [HIST_AW-1:0] wptr_eff;
    logic [CNT_W:0]     j_plus;
    logic               wrap_end;
    logic [CNT_W-1:0]   counter_next;
    logic [HIST_AW-1:0] wptr_next;
    logic               has_result;

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && (state_reg == S_IDLE);
    assign restart  = ({1'b0, cell_counter_reg} >= total);
    assign j_eff    = restart ? '0 : cell_counter_reg;
    assign wptr_eff = restart ? '0 : wptr_reg;
    assign j_plus   = {1'b0, j_eff} + (CNT_W + 1)'(1);
    assign wrap_end = (j_plus >= total);
    assign counter_next = wrap_end ? '0 : CNT_W'(j_plus);
    assign wptr_next = (wrap_end || (32'(wptr_eff) == HIST_DEPTH - 1)) ? '0
                       : wptr_eff + HIST_AW'(1);
    assign has_result = ({1'b0, j_eff} >= ((CNT_W + 1)'(nc) << 1) + (CNT_W + 1)'(2));

    // ------------------------------------------------------------- history
    logic [HIST_AW:0]   lag;
    logic [HIST_AW:0]   rd_diff;
    logic [HIST_AW-1:0] rd_addr;
    logic               rd_en;
    logic [CELL_W-1:0]  rd_data;

    always_comb
    begin
        unique case (rd_idx_reg[2:0])
            3'd0:    lag = ((HIST_AW + 1)'(nc_reg) << 1) + (HIST_AW + 1)'(2);
            3'd1:    lag = ((HIST_AW + 1)'(nc_reg) << 1) + (HIST_AW + 1)'(1);
            3'd2:    lag = ((HIST_AW + 1)'(nc_reg) << 1);
            3'd3:    lag = (HIST_AW + 1)'(nc_reg) + (HIST_AW + 1)'(2);
            3'd4:    lag = (HIST_AW + 1)'(nc_reg) + (HIST_AW + 1)'(1);
            3'd5:    lag = (HIST_AW + 1)'(nc_reg);
            3'd6:    lag = (HIST_AW + 1)'(2);
            3'd7:    lag = (HIST_AW + 1)'(1);
            default: lag = '0;
        endcase
        rd_diff = {1'b0, wcur_reg} - lag;
        if (rd_diff[HIST_AW])
            rd_addr = HIST_AW'(rd_diff + (HIST_AW + 1)'(HIST_DEPTH));
        else
            rd_addr = rd_diff[HIST_AW-1:0];
    end

    assign rd_en = (state_reg == S_READ) && !rd_idx_reg[3];

    rsa_ram #(
        .WIDTH (CELL_W),
        .DEPTH (HIST_DEPTH)
    ) u_history (
        .clk     (clk),
        .wr_en   (accept),
        .wr_addr (wptr_eff),
        .wr_data ({elevation_valid, elevation}),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // -------------------------------------------------------- stencil sums
    logic signed [SUM_W-1:0] ev [0:8];
    logic signed [SUM_W-1:0] sx, sy;
    logic                    ok;
    logic [MAG_W-1:0]        mx, my;

    always_comb
    begin
        for (int k = 0; k < 8; k++)
        begin
            ev[k] = {{4{win_reg[k][E-1]}}, win_reg[k][E-1:0]};
        end
        ev[8] = {{4{cur_reg[E-1]}}, cur_reg[E-1:0]};
        if (neighbor_mode_reg)
        begin
            sx = (ev[0] + (ev[3] <<< 1) + ev[6]) - (ev[2] + (ev[5] <<< 1) + ev[8]);
            sy = (ev[6] + (ev[7] <<< 1) + ev[8]) - (ev[0] + (ev[1] <<< 1) + ev[2]);
            ok = win_reg[0][E] && win_reg[1][E] && win_reg[2][E] && win_reg[3][E]
                 && win_reg[5][E] && win_reg[6][E] && win_reg[7][E] && cur_reg[E];
        end
        else
        begin
            sx = ev[3] - ev[5];
            sy = ev[7] - ev[1];
            ok = win_reg[1][E] && win_reg[3][E] && win_reg[5][E] && win_reg[7][E];
        end
        mx = sx[SUM_W-1] ? MAG_W'(-sx) : MAG_W'(sx);
        my = sy[SUM_W-1] ? MAG_W'(-sy) : MAG_W'(sy);
    end

    // ----------------------------------------------------- gradient scaling
    logic [MAG_W-1:0]  mul_a;
    logic [15:0]       mul_b;
    logic [PROD_W-1:0] prod_c;
    logic [T_W-1:0]    ty_sum;
    logic [T_W-1:0]    tsx, tsy;
    logic [GRAD_W-1:0] gx_sat, gy_sat;

    always_comb
    begin
        mul_a = (mstep_reg < 3'd2) ? mx_reg : my_reg;
        unique case (mstep_reg[1:0])
            2'd0:    mul_b = x_recip_reg[15:0];
            2'd1:    mul_b = x_recip_reg[31:16];
            2'd2:    mul_b = y_recip_reg[15:0];
            default: mul_b = y_recip_reg[31:16];
        endcase
        prod_c = mul_a * mul_b;
        ty_sum = ty_reg + T_W'(prod_reg);
        tsx = neighbor_mode_reg ? (tx_reg >> 3) : (tx_reg >> 1);
        tsy = neighbor_mode_reg ? (ty_sum >> 3) : (ty_sum >> 1);
        gx_sat = (64'(tsx) > GRAD_CAP) ? GRAD_W'(GRAD_CAP) : GRAD_W'(tsx);
        gy_sat = (64'(tsy) > GRAD_CAP) ? GRAD_W'(GRAD_CAP) : GRAD_W'(tsy);
    end

    // ------------------------------------------ magnitude and square root
    logic        grad_big;
    logic [30:0] sq_op;
    logic [61:0] sq_c;
    logic [5:0]  bit_sh;
    logic [63:0] bit_c;
    logic [63:0] trial;
    logic        take;
    logic [63:0] res_next;

    always_comb
    begin
        grad_big = |((gx_reg | gy_reg) >> 31);
        sq_op    = sqstep_reg ? gy_reg[30:0] : gx_reg[30:0];
        sq_c     = sq_op * sq_op;
        bit_sh   = 6'd62 - {it_reg, 1'b0};
        bit_c    = 64'd1 << bit_sh;
        trial    = res_reg + bit_c;
        take     = ({1'b0, n_reg} >= trial);
        res_next = take ? ((res_reg >> 1) + bit_c) : (res_reg >> 1);
    end

    // --------------------------------------------------------------- CORDIC
    function automatic logic signed [CW-1:0] shr_tz(input logic signed [CW-1:0] v,
                                                     input logic [4:0] k);
        logic signed [CW-1:0] m;
        begin
            m = -v;
            if (v[CW-1])
                return -(m >> k);
            return v >> k;
        end
    endfunction

    logic signed [CW-1:0] x_sh, y_sh;
    logic                 pre_go;
    logic [Z_W-2:0]       zc;
    logic [DP_W:0]        deg_round;
    logic [ANGLE_W-1:0]   deg_angle, rad_angle;
    logic [Z_W-1:0]       rad_full;

    always_comb
    begin
        x_sh   = shr_tz(x_reg, it_reg);
        y_sh   = shr_tz(y_reg, it_reg);
        pre_go = (x_reg < (CW'(1) <<< 30)) && (y_reg < (CW'(1) <<< 30));
        zc     = z_reg[Z_W-1] ? '0 : z_reg[Z_W-2:0];
        deg_round = {1'b0, dp_reg} + ((DP_W + 1)'(1) << 31);
        if ((deg_round >> 32) > (DP_W + 1)'(NINETY_Q16))
            deg_angle = NINETY_Q16;
        else
            deg_angle = ANGLE_W'(deg_round >> 32);
        rad_full = ({1'b0, zc} + Z_W'(128)) >> 8;
        if (rad_full > Z_W'(HALF_PI_Q16))
            rad_angle = HALF_PI_Q16;
        else
            rad_angle = ANGLE_W'(rad_full);
    end

    // ---------------------------------------------------------- control
    logic out_load;

    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            neighbor_mode_reg <= 1'b1;
            unit_mode_reg     <= 1'b1;
            x_recip_reg       <= 32'd16777216;
            y_recip_reg       <= 32'd16777216;
            column_count_reg  <= 11'd1024;
            row_count_reg     <= 11'd1024;
            cell_counter_reg  <= '0;
            wptr_reg          <= '0;
            rd_idx_reg        <= '0;
            mstep_reg         <= '0;
            sqstep_reg        <= 1'b0;
            it_reg            <= '0;
            cstep_reg         <= 1'b0;
            s_reg             <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_NEIGHBOR_MODE: neighbor_mode_reg <= cfg_data[0];
                    CFG_UNIT_MODE:     unit_mode_reg     <= cfg_data[0];
                    CFG_X_RECIPROCAL:  x_recip_reg       <= cfg_data;
                    CFG_Y_RECIPROCAL:  y_recip_reg       <= cfg_data;
                    CFG_COLUMN_COUNT:  column_count_reg  <= cfg_data[10:0];
                    CFG_ROW_COUNT:     row_count_reg     <= cfg_data[10:0];
                    default:           ;
                endcase
            end

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        cell_counter_reg <= counter_next;
                        wptr_reg         <= wptr_next;
                        rd_idx_reg       <= '0;
                        if (has_result)
                            state_reg <= S_READ;
                    end
                end
                S_READ:
                begin
                    rd_idx_reg <= rd_idx_reg + 4'd1;
                    if (rd_idx_reg == 4'd8)
                        state_reg <= S_SUM;
                end
                S_SUM:
                begin
                    mstep_reg <= '0;
                    state_reg <= ok ? S_MUL : S_DONE;
                end
                S_MUL:
                begin
                    mstep_reg <= mstep_reg + 3'd1;
                    if (mstep_reg == 3'd4)
                    begin
                        s_reg     <= '0;
                        state_reg <= S_NORM;
                    end
                end
                S_NORM:
                begin
                    if ((gx_reg == '0) && (gy_reg == '0))
                        state_reg <= S_DONE;
                    else if (grad_big)
                        s_reg <= s_reg + 5'd1;
                    else
                    begin
                        sqstep_reg <= 1'b0;
                        state_reg  <= S_SQ;
                    end
                end
                S_SQ:
                begin
                    sqstep_reg <= 1'b1;
                    if (sqstep_reg)
                    begin
                        it_reg    <= '0;
                        state_reg <= S_SQRT;
                    end
                end
                S_SQRT:
                begin
                    it_reg <= it_reg + 5'd1;
                    if (it_reg == 5'd31)
                        state_reg <= S_PRE;
                end
                S_PRE:
                begin
                    if (!pre_go)
                    begin
                        it_reg    <= '0;
                        state_reg <= S_CORDIC;
                    end
                end
                S_CORDIC:
                begin
                    it_reg <= it_reg + 5'd1;
                    if (it_reg == 5'd23)
                    begin
                        cstep_reg <= 1'b0;
                        state_reg <= S_CONV;
                    end
                end
                S_CONV:
                begin
                    cstep_reg <= 1'b1;
                    if (cstep_reg)
                        state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (out_load)
                        state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // ---------------------------------------------------------- datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    j_reg    <= j_eff;
                    wcur_reg <= wptr_eff;
                    nc_reg   <= nc;
                    cur_reg  <= {elevation_valid, elevation};
                end
            end
            S_READ:
            begin
                if (rd_idx_reg != 4'd0)
                    win_reg[3'(rd_idx_reg - 4'd1)] <= rd_data;
            end
            S_SUM:
            begin
                mx_reg    <= mx;
                my_reg    <= my;
                ok_reg    <= ok;
                angle_reg <= '0;
            end
            S_MUL:
            begin
                prod_reg <= prod_c;
                unique case (mstep_reg)
                    3'd1:    tx_reg <= T_W'(prod_reg >> 16);
                    3'd2:    tx_reg <= tx_reg + T_W'(prod_reg);
                    3'd3:    ty_reg <= T_W'(prod_reg >> 16);
                    3'd4:
                    begin
                        gx_reg <= gx_sat;
                        gy_reg <= gy_sat;
                    end
                    default: ;
                endcase
            end
            S_NORM:
            begin
                if (grad_big)
                begin
                    gx_reg <= gx_reg >> 1;
                    gy_reg <= gy_reg >> 1;
                end
            end
            S_SQ:
            begin
                if (sqstep_reg)
                    n_reg <= sq_reg + 63'(sq_c);
                else
                    sq_reg <= 63'(sq_c);
                res_reg <= '0;
            end
            S_SQRT:
            begin
                if (take)
                    n_reg <= n_reg - 63'(trial);
                res_reg <= res_next;
                if (it_reg == 5'd31)
                begin
                    x_reg <= CW'(1) <<< (5'd16 - s_reg);
                    y_reg <= CW'(res_next[31:0]);
                end
            end
            S_PRE:
            begin
                z_reg <= '0;
                if (pre_go)
                begin
                    x_reg <= x_reg <<< 1;
                    y_reg <= y_reg <<< 1;
                end
            end
            S_CORDIC:
            begin
                if (y_reg > 0)
                begin
                    x_reg <= x_reg + y_sh;
                    y_reg <= y_reg - x_sh;
                    z_reg <= z_reg + atan_q24(it_reg);
                end
                else
                begin
                    x_reg <= x_reg - y_sh;
                    y_reg <= y_reg + x_sh;
                    z_reg <= z_reg - atan_q24(it_reg);
                end
            end
            S_CONV:
            begin
                if (!cstep_reg)
                    dp_reg <= zc * DEG_SCALE;
                else
                    angle_reg <= unit_mode_reg ? deg_angle : rad_angle;
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    slope_angle_reg <= angle_reg;
                    slope_valid_reg <= ok_reg;
                    cell_index_reg  <= INDEX_W'(j_reg - CNT_W'(nc_reg) - CNT_W'(1));
                end
            end
            default: ;
        endcase
    end

    assign out_valid   = out_valid_reg;
    assign slope_angle = slope_angle_reg;
    assign slope_valid = slope_valid_reg;
    assign cell_index  = cell_index_reg;

    // --------------------------------------------------------- assertions
    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state register is not one-hot");

    a_wptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(wptr_reg) < HIST_DEPTH)
        else $error("history write pointer beyond memory depth");

    a_missing_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !slope_valid_reg |-> slope_angle_reg == '0)
        else $error("invalid result carries a nonzero angle");

    a_angle_cap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> slope_angle_reg <= NINETY_Q16)
        else $error("slope angle above ninety degrees");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall && state_reg == S_DONE |=> state_reg == S_DONE)
        else $error("result transaction overwritten while stalled");

endmodule

`default_nettype wire

@@ src/rsa_ram.sv @@
// ----------------------------------------------------------------------------
// rsa_ram
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module rsa_ram #(
    parameter int WIDTH = 25,
    parameter int DEPTH = 2051
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire
